[rtl/ile_pkg.sv]
// Shared types and defaults for the indexed list engine.
// Holds request and status codes, the cell command struct and parameter defaults.
// No dependencies.
package ile_pkg;

   // Default sizes of the list.
   localparam int DEPTH_DEF  = 16;
   localparam int WORD_W_DEF = 32;

   // Request codes carried in the request tuser.
   typedef enum logic [2:0] {
      REQ_ADD_BACK   = 3'd0,
      REQ_ADD_FRONT  = 3'd1,
      REQ_POP_BACK   = 3'd2,
      REQ_POP_FRONT  = 3'd3,
      REQ_INSERT     = 3'd4,
      REQ_REMOVE     = 3'd5,
      REQ_REVERSE    = 3'd6,
      REQ_NONE       = 3'd7
   } req_code_type;

   // Status codes carried in the response tuser.
   typedef enum logic [1:0] {
      STS_OK     = 2'd0,
      STS_EMPTY  = 2'd1,
      STS_FULL   = 2'd2,
      STS_BADIDX = 2'd3
   } status_type;

   // What every cell of the row does.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_LOAD_TAG,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
   } cell_cmd_type;

endpackage

[rtl/ile_cell.sv]
// One storage cell of the list row: a data word plus a destination tag.
// Shifts with its neighbors on insert and remove, and does odd-even exchange
// on the tags during a reverse. Depends on ile_pkg.
module ile_cell #(
   parameter int DEPTH  = ile_pkg::DEPTH_DEF,
   parameter int WORD_W = ile_pkg::WORD_W_DEF,
   parameter int IDX    = 0
) (
   input  logic                             clock,
   input  ile_pkg::cell_cmd_type            cmd,
   input  logic [$clog2(DEPTH+1)-1:0]       pos,
   input  logic [$clog2(DEPTH+1)-1:0]       cnt,
   input  logic [WORD_W-1:0]                word_new,
   input  logic [WORD_W-1:0]                left_word,
   input  logic [$clog2(DEPTH)-1:0]         left_tag,
   input  logic [WORD_W-1:0]                right_word,
   input  logic [$clog2(DEPTH)-1:0]         right_tag,
   output logic [WORD_W-1:0]                word_q,
   output logic [$clog2(DEPTH)-1:0]         tag_q
);
   import ile_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
   localparam logic [IDX_W-1:0] MY_TAG = IDX_W'(IDX);
   localparam logic IS_FIRST = (IDX == 0);
   localparam logic IS_LAST  = (IDX == DEPTH - 1);
   localparam logic PAR      = ((IDX % 2) == 1);

   logic [WORD_W-1:0] word_ff, word_in;
   logic [IDX_W-1:0]  tag_ff, tag_in;

   // Next word and tag from the broadcast command and the neighbors.
   always_comb begin
      word_in = word_ff;
      tag_in  = tag_ff;
      unique case (cmd.op)
         CELL_INSERT: begin
            if (MY_CNT == pos) begin
               word_in = word_new;
            end else if (MY_CNT > pos && MY_CNT <= cnt && !IS_FIRST) begin
               word_in = left_word;
            end
         end
         CELL_REMOVE: begin
            if (MY_CNT >= pos && ({1'b0, MY_CNT} + 1'b1) < {1'b0, cnt} && !IS_LAST) begin
               word_in = right_word;
            end
         end
         CELL_LOAD_TAG: begin
            // Cells inside the list aim at the mirrored place; the rest stay put.
            if (MY_CNT < cnt) begin
               tag_in = IDX_W'(cnt - MY_CNT - 1'b1);
            end else begin
               tag_in = MY_TAG;
            end
         end
         CELL_SORT: begin
            if (cmd.phase == PAR && !IS_LAST) begin
               if (tag_ff > right_tag) begin
                  word_in = right_word;
                  tag_in  = right_tag;
               end
            end else if (cmd.phase != PAR && !IS_FIRST) begin
               if (left_tag > tag_ff) begin
                  word_in = left_word;
                  tag_in  = left_tag;
               end
            end
         end
         default: begin
            word_in = word_ff;
            tag_in  = tag_ff;
         end
      endcase
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      word_ff <= word_in;
      tag_ff  <= tag_in;
   end

   assign word_q = word_ff;
   assign tag_q  = tag_ff;

endmodule

[rtl/indexed_list_engine_unit.sv]
// Indexed list engine: an ordered list of DEPTH words kept in a row of cells.
// For push, pop, insert and remove the response is registered and shows in the
// cycle after the request transaction, one per cycle while the response port is
// ready. Reverse responds the same way, then, for a list of two or more words, the
// row runs DEPTH odd-even exchange rounds, during which no request is taken.
// Reset is synchronous, active high, and empties the list; cell words are not cleared.
module indexed_list_engine_unit #(
   parameter int DEPTH  = ile_pkg::DEPTH_DEF,
   parameter int WORD_W = ile_pkg::WORD_W_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // position, word_in (from bit 0), zero padded to bytes
   input  logic [((($clog2(DEPTH+1) + WORD_W) + 7) / 8) * 8 - 1:0] req_tdata,
   // req_type
   input  logic [2:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // word_out, count_out (from bit 0), zero padded to bytes
   output logic [((($clog2(DEPTH+1) + WORD_W) + 7) / 8) * 8 - 1:0] rsp_tdata,
   // status
   output logic [1:0] rsp_tuser
);
   import ile_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int DATA_W = ((CNT_W + WORD_W + 7) / 8) * 8;
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_RND  = IDX_W'(DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SORT = 2'b10
   } fsm_type;

   // Request fields.
   req_code_type      req_code;
   logic [CNT_W-1:0]  req_pos;
   logic [WORD_W-1:0] req_word;
   logic              req_fire;

   assign req_code = req_code_type'(req_tuser);
   assign req_pos  = req_tdata[CNT_W-1:0];
   assign req_word = req_tdata[CNT_W +: WORD_W];

   fsm_type           state_ff, state_in;
   logic [IDX_W-1:0]  round_ff, round_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_word_ff, rsp_word_in;
   logic [CNT_W-1:0]  rsp_count_ff;

   cell_cmd_type      cmd;
   logic [CNT_W-1:0]  cell_pos;
   logic [IDX_W-1:0]  rd_idx;
   logic [WORD_W-1:0] rd_word;

   logic [WORD_W-1:0] cell_word [DEPTH];
   logic [IDX_W-1:0]  cell_tag  [DEPTH];

   // Take a request only between reverses and when the response slot frees up.
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   // Word taken out by a pop or remove.
   assign rd_word = cell_word[rd_idx];

   // Request decode and exchange rounds: status, new count, row command and read place.
   always_comb begin
      count_in      = count_ff;
      state_in      = state_ff;
      round_in      = round_ff;
      rsp_status_in = STS_OK;
      rsp_word_in   = '0;
      cmd.op        = CELL_HOLD;
      cmd.phase     = round_ff[0];
      cell_pos      = req_pos;
      rd_idx        = req_pos[IDX_W-1:0];
      unique case (state_ff)
         ST_SORT: begin
            cmd.op   = CELL_SORT;
            round_in = round_ff + 1'b1;
            if (round_ff == LAST_RND) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_code)
                  REQ_ADD_BACK, REQ_ADD_FRONT, REQ_INSERT: begin
                     if (req_code == REQ_ADD_BACK) begin
                        cell_pos = count_ff;
                     end else if (req_code == REQ_ADD_FRONT) begin
                        cell_pos = '0;
                     end
                     if (req_code == REQ_INSERT && req_pos > count_ff) begin
                        rsp_status_in = STS_BADIDX;
                     end else if (count_ff == FULL_CNT) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        cmd.op   = CELL_INSERT;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  REQ_POP_BACK, REQ_POP_FRONT, REQ_REMOVE: begin
                     if (req_code == REQ_POP_BACK) begin
                        cell_pos = count_ff - 1'b1;
                     end else if (req_code == REQ_POP_FRONT) begin
                        cell_pos = '0;
                     end
                     rd_idx = cell_pos[IDX_W-1:0];
                     if (count_ff == '0) begin
                        rsp_status_in = STS_EMPTY;
                     end else if (req_code == REQ_REMOVE && req_pos >= count_ff) begin
                        rsp_status_in = STS_BADIDX;
                     end else begin
                        cmd.op      = CELL_REMOVE;
                        count_in    = count_ff - 1'b1;
                        rsp_word_in = rd_word;
                     end
                  end
                  REQ_REVERSE: begin
                     if (count_ff > CNT_W'(1)) begin
                        cmd.op   = CELL_LOAD_TAG;
                        state_in = ST_SORT;
                        round_in = '0;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response slot fills on a request and empties on a response transaction.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_status_ff <= rsp_status_in;
         rsp_word_ff   <= rsp_word_in;
         rsp_count_ff  <= count_in;
      end
   end

   // Row of cells, each wired to its two neighbors.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] lw, rw;
      logic [IDX_W-1:0]  lt, rt;
      if (g == 0) begin : g_lf
         assign lw = '0;
         assign lt = '0;
      end else begin : g_ln
         assign lw = cell_word[g-1];
         assign lt = cell_tag[g-1];
      end
      if (g == DEPTH - 1) begin : g_rf
         assign rw = '0;
         assign rt = '0;
      end else begin : g_rn
         assign rw = cell_word[g+1];
         assign rt = cell_tag[g+1];
      end
      ile_cell #(
         .DEPTH  (DEPTH),
         .WORD_W (WORD_W),
         .IDX    (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .pos        (cell_pos),
         .cnt        (count_ff),
         .word_new   (req_word),
         .left_word  (lw),
         .left_tag   (lt),
         .right_word (rw),
         .right_tag  (rt),
         .word_q     (cell_word[g]),
         .tag_q      (cell_tag[g])
      );
   end

   // Response ports.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = DATA_W'({rsp_count_ff, rsp_word_ff});

   // The count never passes the list depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("list count above depth");

   // The count moves only as the result of a request transaction.
   a_count_stable: assert property (@(posedge clock) disable iff (reset)
      !req_fire |=> $stable(count_ff))
      else $error("list count changed without a request");

   // Every request leaves a response that reports the new count.
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff && rsp_count_ff == count_ff))
      else $error("response count does not match list count");

   // A reverse of two or more words starts the exchange rounds.
   a_rev_sort: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_code == REQ_REVERSE && count_ff > CNT_W'(1))
      |=> (state_ff == ST_SORT && round_ff == '0))
      else $error("reverse did not start exchange rounds");

endmodule
